>>> hdl/xbdf_pkg.sv
// Package for the XOR basis dependency finder.
// Holds port widths, register codes and the controller/datapath interface types.
// No dependencies.
package xbdf_pkg;

  // Default sizes handed to the top level parameters.
  localparam int VEC_BITS_DEF = 64;
  localparam int ID_COUNT_DEF = 64;

  // Fixed field widths of the item payloads.
  localparam int VECTOR_FIELD_W = 64;
  localparam int ID_FIELD_W     = 6;
  localparam int PIVOT_FIELD_W  = 6;
  localparam int MASK_FIELD_W   = 64;
  localparam int IN_TDATA_W     = 72;
  localparam int OUT_TDATA_W    = 72;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WIDTH_REG_W = 7;
  localparam logic [CFG_ADDR_W-1:0]  REG_VECTOR_WIDTH = 2'd0;
  localparam logic [WIDTH_REG_W-1:0] VECTOR_WIDTH_RESET = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new input item and set the scan bit
    logic step;    // fold the current bit's row in and move one bit down
    logic finish;  // store the row if independent and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;    // the current bit ends the reduction
  } dp_stat_t;

endpackage

>>> hdl/xbdf_ctrl.sv
// Controller for the XOR basis dependency finder.
// Sequences the bit scan and owns the input ready and result valid flags.
// Depends on xbdf_pkg.
module xbdf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  xbdf_pkg::dp_stat_t stat,
  output xbdf_pkg::dp_cmd_t  cmd
);
  import xbdf_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          // The result register is free or empties this cycle.
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.finish)
    else $error("result overwritten while still pending");

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SCAN))
    else $error("accepted item did not start a scan");

  a_step_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !stat.done)
    else $error("scan stepped past its final bit");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished item did not raise a result");
`endif

endmodule

>>> hdl/xbdf_dp.sv
// Datapath for the XOR basis dependency finder.
// Holds the basis row memory, row valid flags, working vector and mask, and result register.
// Depends on xbdf_pkg.
module xbdf_dp #(
  parameter int VEC_BITS = xbdf_pkg::VEC_BITS_DEF,
  parameter int ID_COUNT = xbdf_pkg::ID_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  xbdf_pkg::dp_cmd_t                    cmd,
  output xbdf_pkg::dp_stat_t                   stat,
  input  logic [xbdf_pkg::VECTOR_FIELD_W-1:0]  in_vec,
  input  logic [xbdf_pkg::ID_FIELD_W-1:0]      in_id,
  input  logic [xbdf_pkg::WIDTH_REG_W-1:0]     vector_width,
  output logic                                 res_dependent,
  output logic [xbdf_pkg::PIVOT_FIELD_W-1:0]   res_pivot,
  output logic [xbdf_pkg::MASK_FIELD_W-1:0]    res_mask
);
  import xbdf_pkg::*;

  localparam int BIT_W = (VEC_BITS > 1) ? $clog2(VEC_BITS) : 1;
  localparam int ROW_W = VEC_BITS + ID_COUNT;
  localparam logic [WIDTH_REG_W-1:0] VEC_BITS_CFG = WIDTH_REG_W'(VEC_BITS);

  // Each memory row holds the combination mask above the reduced vector.
  logic [ROW_W-1:0]    row_mem [VEC_BITS];
  logic [ROW_W-1:0]    rd_data_r;
  logic [BIT_W-1:0]    rd_addr;
  logic [VEC_BITS-1:0] row_valid_r;

  logic [VEC_BITS-1:0] vec_r;
  logic [ID_COUNT-1:0] comb_r;
  logic [BIT_W-1:0]    bit_r;

  logic                dep_r;
  logic [BIT_W-1:0]    pivot_r;
  logic [ID_COUNT-1:0] mask_r;

  logic [WIDTH_REG_W-1:0] width_eff;
  logic [BIT_W-1:0]       start_bit;
  logic [VEC_BITS-1:0]    in_vec_masked;
  logic [ID_COUNT-1:0]    in_comb;
  logic                   bit_set;
  logic                   fold;
  logic                   independent;
  logic [VEC_BITS-1:0]    row_vec;
  logic [ID_COUNT-1:0]    row_mask;
  logic [ID_COUNT-1:0]    comb_folded;

  // Width clamped to 1..VEC_BITS; the scan starts at its top bit.
  always_comb begin
    if (vector_width == '0) begin
      width_eff = WIDTH_REG_W'(1);
    end else if (vector_width > VEC_BITS_CFG) begin
      width_eff = VEC_BITS_CFG;
    end else begin
      width_eff = vector_width;
    end
    start_bit = BIT_W'(width_eff - WIDTH_REG_W'(1));
  end

  always_comb begin
    for (int i = 0; i < VEC_BITS; i++) begin
      in_vec_masked[i] = in_vec[i] && (WIDTH_REG_W'(i) < width_eff);
    end
    for (int j = 0; j < ID_COUNT; j++) begin
      in_comb[j] = (in_id == ID_FIELD_W'(j));
    end
  end

  assign row_vec     = rd_data_r[VEC_BITS-1:0];
  assign row_mask    = rd_data_r[ROW_W-1:VEC_BITS];
  assign bit_set     = vec_r[bit_r];
  assign independent = bit_set && !row_valid_r[bit_r];
  assign fold        = bit_set && row_valid_r[bit_r];
  assign comb_folded = fold ? (comb_r ^ row_mask) : comb_r;
  assign stat.done   = independent || (bit_r == '0);

  // Rows are prefetched one bit ahead so that the row for bit_r is on hand.
  always_comb begin
    if (cmd.load) begin
      rd_addr = start_bit;
    end else if (cmd.step) begin
      rd_addr = bit_r - BIT_W'(1);
    end else begin
      rd_addr = bit_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= row_mem[rd_addr];
    if (cmd.finish && independent) begin
      row_mem[bit_r] <= {comb_r, vec_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.finish && independent) begin
      row_valid_r[bit_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vec_r  <= in_vec_masked;
      comb_r <= in_comb;
      bit_r  <= start_bit;
    end else if (cmd.step) begin
      if (fold) begin
        vec_r <= vec_r ^ row_vec;
      end
      comb_r <= comb_folded;
      bit_r  <= bit_r - BIT_W'(1);
    end
    if (cmd.finish) begin
      dep_r   <= !independent;
      pivot_r <= independent ? bit_r : '0;
      mask_r  <= independent ? comb_r : comb_folded;
    end
  end

  assign res_dependent = dep_r;
  assign res_pivot     = PIVOT_FIELD_W'(pivot_r);
  assign res_mask      = MASK_FIELD_W'(mask_r);

endmodule

>>> hdl/xor_basis_dependency_finder.sv
// An item is scanned one bit per cycle from the top bit in use down to its free pivot or
// bit 0, the top bit set by vector_width clamped to 1..VEC_BITS; its result is loaded once
// the scan ends and the result register is free, any previous result taken on out_tready.
// A new item is accepted only after the previous item's result is loaded; the basis row
// memory has a single read port, visited once per bit.
// Synchronous active-low reset clears row valid, result valid and sets vector_width to 64.
module xor_basis_dependency_finder #(
  parameter int VEC_BITS = xbdf_pkg::VEC_BITS_DEF,
  parameter int ID_COUNT = xbdf_pkg::ID_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input items.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: vector_bits [63:0], item_id [69:64], zero fill [71:70].
  input  logic [xbdf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result items.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: pivot_row [5:0], combination_mask [69:6], zero fill [71:70].
  output logic [xbdf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Fields from bit 0: dependent [0].
  output logic [0:0]                        out_tuser,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [xbdf_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [xbdf_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [xbdf_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import xbdf_pkg::*;

  logic [WIDTH_REG_W-1:0]   vector_width_r;
  logic                     cfg_write;
  dp_cmd_t                  cmd;
  dp_stat_t                 stat;
  logic                     res_dependent;
  logic [PIVOT_FIELD_W-1:0] res_pivot;
  logic [MASK_FIELD_W-1:0]  res_mask;

  // The register file holds only vector_width. Writes to any other address are dropped.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_width_r <= VECTOR_WIDTH_RESET;
    end else if (cfg_write && (cfg_paddr == REG_VECTOR_WIDTH)) begin
      vector_width_r <= cfg_pwdata[WIDTH_REG_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr)
      REG_VECTOR_WIDTH: cfg_prdata = CFG_DATA_W'(vector_width_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // The controller only sequences; all vector and mask state sits in the datapath.
  xbdf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  xbdf_dp #(
    .VEC_BITS (VEC_BITS),
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_vec        (in_tdata[VECTOR_FIELD_W-1:0]),
    .in_id         (in_tdata[VECTOR_FIELD_W +: ID_FIELD_W]),
    .vector_width  (vector_width_r),
    .res_dependent (res_dependent),
    .res_pivot     (res_pivot),
    .res_mask      (res_mask)
  );

  // The result register in the datapath lets a new item enter while a result waits.
  assign out_tdata = {{(OUT_TDATA_W - PIVOT_FIELD_W - MASK_FIELD_W){1'b0}}, res_mask, res_pivot};
  assign out_tuser = res_dependent;

endmodule
